// File: hdl/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg: shared definitions for the keyed LRU cache
// Field widths, default sizes, operation codes and the store write control.
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam int unsigned NUM_ENTRIES_DEF   = 8;
  localparam int unsigned PAYLOAD_WIDTH_DEF = 32;

  localparam int unsigned KEY_W     = 24;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PAY_IO_W  = 32;
  localparam int unsigned SLOT_W    = 3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Write enables for one entry of the store; key_we also marks the entry valid.
  typedef struct packed {
    logic key_we;
    logic payload_we;
    logic time_we;
  } lkc_wr_ctl_t;

endpackage

// File: hdl/lkc_req_if.sv
// ----------------------------------------------------------------------------
// lkc_req_if: request channel of the keyed LRU cache
// Valid/ready channel carrying one lookup or insert request.
// ----------------------------------------------------------------------------
interface lkc_req_if;

  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [lkc_pkg::KEY_W-1:0]    key;
  logic [lkc_pkg::PAY_IO_W-1:0] payload_in;
  logic [lkc_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output op, output key, output payload_in,
                  output now_ms, input ready);
  modport sink   (input valid, input op, input key, input payload_in,
                  input now_ms, output ready);

endinterface

// File: hdl/lkc_rsp_if.sv
// ----------------------------------------------------------------------------
// lkc_rsp_if: response channel of the keyed LRU cache
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface lkc_rsp_if;

  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lkc_pkg::PAY_IO_W-1:0] payload_out;
  logic [lkc_pkg::SLOT_W-1:0]   slot;
  logic                         evicted;

  modport source (output valid, output hit, output payload_out, output slot,
                  output evicted, input ready);
  modport sink   (input valid, input hit, input payload_out, input slot,
                  input evicted, output ready);

endinterface

// File: hdl/lkc_store.sv
// ----------------------------------------------------------------------------
// lkc_store: entry storage of the keyed LRU cache
// Key, payload and timestamp memories with one registered read port and one
// write port, plus per-entry valid flops cleared at reset.
// ----------------------------------------------------------------------------
module lkc_store #(
  parameter int unsigned NUM_ENTRIES   = lkc_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned PAYLOAD_WIDTH = lkc_pkg::PAYLOAD_WIDTH_DEF,
  localparam int unsigned IDX_W        = $clog2(NUM_ENTRIES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [IDX_W-1:0]            rd_addr_i,
  input  lkc_pkg::lkc_wr_ctl_t        wr_ctl_i,
  input  logic [IDX_W-1:0]            wr_addr_i,
  input  logic [lkc_pkg::KEY_W-1:0]   wr_key_i,
  input  logic [PAYLOAD_WIDTH-1:0]    wr_payload_i,
  input  logic [lkc_pkg::TIME_W-1:0]  wr_time_i,
  output logic                        rd_valid_o,
  output logic [lkc_pkg::KEY_W-1:0]   rd_key_o,
  output logic [PAYLOAD_WIDTH-1:0]    rd_payload_o,
  output logic [lkc_pkg::TIME_W-1:0]  rd_time_o
);
  import lkc_pkg::*;

  logic [NUM_ENTRIES-1:0] valid_q;
  logic                   rd_valid_q;

  logic [KEY_W-1:0]         key_mem  [NUM_ENTRIES];
  logic [PAYLOAD_WIDTH-1:0] pay_mem  [NUM_ENTRIES];
  logic [TIME_W-1:0]        time_mem [NUM_ENTRIES];

  logic [KEY_W-1:0]         rd_key_q;
  logic [PAYLOAD_WIDTH-1:0] rd_pay_q;
  logic [TIME_W-1:0]        rd_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_ctl_i.key_we) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.key_we) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (wr_ctl_i.payload_we) begin
      pay_mem[wr_addr_i] <= wr_payload_i;
    end
    if (wr_ctl_i.time_we) begin
      time_mem[wr_addr_i] <= wr_time_i;
    end
    if (rd_en_i) begin
      rd_key_q  <= key_mem[rd_addr_i];
      rd_pay_q  <= pay_mem[rd_addr_i];
      rd_time_q <= time_mem[rd_addr_i];
    end
  end

  assign rd_valid_o   = rd_valid_q;
  assign rd_key_o     = rd_key_q;
  assign rd_payload_o = rd_pay_q;
  assign rd_time_o    = rd_time_q;

  // The walk reads and the final update writes; they never share a cycle.
  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !(wr_ctl_i.key_we || wr_ctl_i.payload_we || wr_ctl_i.time_we))
    else $error("store read and write in the same cycle");

  // Key and payload are only ever written together.
  a_key_pay_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ctl_i.key_we == wr_ctl_i.payload_we)
    else $error("key and payload write enables differ");

endmodule

// File: hdl/lru_keyed_cache_top.sv
// ----------------------------------------------------------------------------
// lru_keyed_cache_top: fully associative LRU cache keyed by aircraft address
// Usage:
//   req_i carries one request per transfer: op (lookup or insert), a 24-bit
//   key, a payload handle and the current time in ms. rsp_o returns exactly
//   one result per request: hit, payload_out, slot and evicted.
//   A lookup that hits returns the payload and restamps the entry. An insert
//   refreshes a matching entry, else fills the lowest free entry, else
//   evicts the entry with the smallest stamp (lowest index on a tie).
// Timing:
//   One compare unit walks the entries, one per cycle, through the registered
//   read port of the entry store. After the transfer the block walks every
//   entry, then updates the store and the result register. req_i.ready rises
//   in the same cycle that rsp_o.valid does; a request is taken only once the
//   last has its result. The result register lets the next request walk while
//   the last result waits; a stalled rsp_o holds the block at its update step.
// Reset:
//   rst_ni clears all valid bits at once; the block is ready right after.
// ----------------------------------------------------------------------------
module lru_keyed_cache_top #(
  parameter int unsigned NUM_ENTRIES   = lkc_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned PAYLOAD_WIDTH = lkc_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lkc_req_if.sink      req_i,
  lkc_rsp_if.source    rsp_o
);
  import lkc_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]   st_q, st_d;
  logic [IDX_W:0] iss_q, iss_d;
  logic           cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;

  // Latched request
  logic                     op_q;
  logic [KEY_W-1:0]         key_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;
  logic [TIME_W-1:0]        now_q;

  // Walk results
  logic                     match_q, match_d;
  logic [IDX_W-1:0]         match_idx_q, match_idx_d;
  logic [PAYLOAD_WIDTH-1:0] match_pay_q, match_pay_d;
  logic                     free_q, free_d;
  logic [IDX_W-1:0]         free_idx_q, free_idx_d;
  logic [IDX_W-1:0]         min_idx_q, min_idx_d;
  logic [TIME_W-1:0]        min_time_q, min_time_d;

  // Result register
  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q;
  logic [PAY_IO_W-1:0]  out_pay_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic                 out_ev_q;

  // Store port
  logic                     rd_en;
  logic                     rd_valid;
  logic [KEY_W-1:0]         rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic [TIME_W-1:0]        rd_time;
  lkc_wr_ctl_t              wr_ctl;

  logic                     req_fire;
  logic                     dec_fire;
  logic                     key_eq;
  logic                     older;
  logic                     last_cmp;
  logic [IDX_W-1:0]         sel_idx;
  logic                     sel_hit;
  logic                     sel_ev;
  logic [PAYLOAD_WIDTH+PAY_IO_W-1:0] pay_in_ext;
  logic [PAYLOAD_WIDTH+PAY_IO_W-1:0] pay_out_ext;
  logic [IDX_W+SLOT_W-1:0]           slot_ext;

  assign req_i.ready = (st_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign pay_in_ext = {{PAYLOAD_WIDTH{1'b0}}, req_i.payload_in};

  lkc_store #(
    .NUM_ENTRIES   (NUM_ENTRIES),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (rd_en),
    .rd_addr_i    (iss_q[IDX_W-1:0]),
    .wr_ctl_i     (wr_ctl),
    .wr_addr_i    (sel_idx),
    .wr_key_i     (key_q),
    .wr_payload_i (pay_q),
    .wr_time_i    (now_q),
    .rd_valid_o   (rd_valid),
    .rd_key_o     (rd_key),
    .rd_payload_o (rd_pay),
    .rd_time_o    (rd_time)
  );

  // Shared compare unit: one entry per cycle.
  assign key_eq   = (rd_key == key_q);
  assign older    = (rd_time < min_time_q);
  assign last_cmp = cmp_v_q && (cmp_idx_q == IDX_W'(NUM_ENTRIES - 1));

  assign rd_en = (st_q == ST_WALK) && (iss_q < (IDX_W+1)'(NUM_ENTRIES));

  always_comb begin
    if (match_q) begin
      sel_idx = match_idx_q;
      sel_hit = 1'b1;
      sel_ev  = 1'b0;
    end else if (op_q == OP_LOOKUP) begin
      sel_idx = '0;
      sel_hit = 1'b0;
      sel_ev  = 1'b0;
    end else if (free_q) begin
      sel_idx = free_idx_q;
      sel_hit = 1'b0;
      sel_ev  = 1'b0;
    end else begin
      sel_idx = min_idx_q;
      sel_hit = 1'b0;
      sel_ev  = 1'b1;
    end
  end

  assign dec_fire = (st_q == ST_DECIDE) && (!out_valid_q || rsp_o.ready);

  assign wr_ctl.key_we     = dec_fire && (op_q == OP_INSERT);
  assign wr_ctl.payload_we = dec_fire && (op_q == OP_INSERT);
  assign wr_ctl.time_we    = dec_fire && ((op_q == OP_INSERT) || match_q);

  assign pay_out_ext = {{PAY_IO_W{1'b0}}, match_pay_q};
  assign slot_ext    = {{SLOT_W{1'b0}}, sel_idx};

  always_comb begin
    st_d        = st_q;
    iss_d       = iss_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    match_pay_d = match_pay_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    min_idx_d   = min_idx_q;
    min_time_d  = min_time_q;
    out_valid_d = out_valid_q;

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (req_fire) begin
          st_d    = ST_WALK;
          iss_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
        end
      end
      ST_WALK: begin
        if (rd_en) begin
          iss_d     = iss_q + 1'b1;
          cmp_v_d   = 1'b1;
          cmp_idx_d = iss_q[IDX_W-1:0];
        end
        if (cmp_v_q) begin
          // Keep the first match and the first hole.
          if (!match_q && rd_valid && key_eq) begin
            match_d     = 1'b1;
            match_idx_d = cmp_idx_q;
            match_pay_d = rd_pay;
          end
          if (!free_q && !rd_valid) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          // Strict compare keeps the lower index on a tie.
          if ((cmp_idx_q == '0) || older) begin
            min_idx_d  = cmp_idx_q;
            min_time_d = rd_time;
          end
        end
        if (last_cmp) begin
          st_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (dec_fire) begin
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      iss_q       <= '0;
      cmp_v_q     <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      iss_q       <= iss_d;
      cmp_v_q     <= cmp_v_d;
      match_q     <= match_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    match_idx_q <= match_idx_d;
    match_pay_q <= match_pay_d;
    free_idx_q  <= free_idx_d;
    min_idx_q   <= min_idx_d;
    min_time_q  <= min_time_d;
    if (req_fire) begin
      op_q  <= req_i.op;
      key_q <= req_i.key;
      pay_q <= pay_in_ext[PAYLOAD_WIDTH-1:0];
      now_q <= req_i.now_ms;
    end
    if (dec_fire) begin
      out_hit_q  <= sel_hit;
      out_slot_q <= slot_ext[SLOT_W-1:0];
      out_ev_q   <= sel_ev;
      out_pay_q  <= ((op_q == OP_LOOKUP) && match_q) ? pay_out_ext[PAY_IO_W-1:0] : '0;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.payload_out = out_pay_q;
  assign rsp_o.slot        = out_slot_q;
  assign rsp_o.evicted     = out_ev_q;

  a_cmp_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_v_q |-> (st_q == ST_WALK))
    else $error("compare data outside the walk");

  a_evict_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_fire && sel_ev) |-> (!free_q && !match_q && (op_q == OP_INSERT)))
    else $error("eviction with a free or matching entry");

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.evicted && rsp_o.hit))
    else $error("result both hit and evicted");

  a_miss_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.hit) |-> (rsp_o.payload_out == '0))
    else $error("payload on a miss");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q <= (IDX_W+1)'(NUM_ENTRIES))
    else $error("walk ran past the last entry");

endmodule
